// ===== design/ipid_pkg.sv =====
// ipid_pkg: shared types, widths and saturation helper for the incremental PID block
// no dependencies; used by ipid_mul and incremental_pid_controller
package ipid_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned OPND_W    = 34;
    localparam int unsigned PROD_W    = 2 * OPND_W;
    localparam int unsigned WIDE_W    = PROD_W + 2;
    localparam int unsigned UNIT_W    = 17;
    localparam int unsigned UNIT_BITS = 16;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [UNIT_W-1:0] UNIT_ONE = 17'h10000;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DT     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CEIL   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IBOUND = 4'd7;

    // request to the serial multiplier
    typedef struct packed {
        logic                     start;
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
    } mul_req_t;

    // answer from the serial multiplier
    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] product;
    } mul_rsp_t;

    // saturate a wide signed value to 32-bit signed
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi_lim;
        logic signed [WIDE_W-1:0] lo_lim;
        hi_lim = WIDE_W'(32'sh7FFF_FFFF);
        lo_lim = -hi_lim - WIDE_W'(1);
        if (v > hi_lim) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo_lim) begin
            return 32'sh8000_0000;
        end
        return v[DATA_W-1:0];
    endfunction

    // 17-bit unit value from the low 17 bits of v; a value above one there acts as one
    function automatic logic [UNIT_W-1:0] unit_clip(input logic [DATA_W-1:0] v);
        if (v[UNIT_W-1:0] > UNIT_ONE) begin
            return UNIT_ONE;
        end
        return v[UNIT_W-1:0];
    endfunction

endpackage

// ===== design/ipid_mul.sv =====
// ipid_mul: radix-2 shift-add signed multiplier, one multiplier bit per cycle
// depends on ipid_pkg
module ipid_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  ipid_pkg::mul_req_t req,
    output ipid_pkg::mul_rsp_t rsp
);
    import ipid_pkg::*;

    localparam logic [5:0] LAST = 6'(OPND_W - 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [5:0]               cnt_reg;
    logic signed [OPND_W-1:0] a_reg;
    logic signed [OPND_W-1:0] hi_reg;
    logic [OPND_W-1:0]        lo_reg;
    logic signed [OPND_W:0]   addend;
    logic signed [OPND_W:0]   sum;

    // top multiplier bit carries negative weight
    always_comb begin
        if (!lo_reg[0]) begin
            addend = '0;
        end else if (cnt_reg == LAST) begin
            addend = -{a_reg[OPND_W-1], a_reg};
        end else begin
            addend = {a_reg[OPND_W-1], a_reg};
        end
        sum = {hi_reg[OPND_W-1], hi_reg} + addend;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // partial product shift line
    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg  <= req.a;
            hi_reg <= '0;
            lo_reg <= req.b;
        end else if (busy_reg) begin
            hi_reg <= sum[OPND_W:1];
            lo_reg <= {sum[0], lo_reg[OPND_W-1:1]};
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = {hi_reg, lo_reg};

endmodule

// ===== design/incremental_pid_controller.sv =====
// incremental_pid_controller: top level of the fixed-point incremental PID loop
// depends on ipid_pkg and ipid_mul
//
// One request carries a measurement, a setpoint and a restart flag and gives one
// drive value. All five products (filter, integral increment, three gain terms)
// share one bit-serial multiplier and are formed one after another; a new request
// is taken only after the last one has reached the output state. A finished
// result sits in the output register, and the next request is taken while it
// waits. Values are signed Q16.16; products round half up and every sum
// saturates to 32 bits. Configuration writes take effect at once and should be
// made only while no request is in flight.
module incremental_pid_controller #(
    parameter int RATE_STEP_LIMIT = 65536,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [ipid_pkg::DATA_W-1:0] s_measured_value,
    input  logic signed [ipid_pkg::DATA_W-1:0] s_setpoint,
    input  logic                              s_restart,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ipid_pkg::DATA_W-1:0] m_drive,
    output logic                              m_limited,
    input  logic                              cfg_wr_en,
    input  logic [ipid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ipid_pkg::DATA_W-1:0]       cfg_data
);
    import ipid_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ISSUE = 8'b0000_0010,
        ST_WAIT  = 8'b0000_0100,
        ST_ERR   = 8'b0000_1000,
        ST_CLAMP = 8'b0001_0000,
        ST_SUM   = 8'b0010_0000,
        ST_LIM   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        OP_FILT, OP_INT, OP_P, OP_I, OP_D
    } op_t;

    localparam logic signed [WIDE_W-1:0] HALF_F = WIDE_W'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [WIDE_W-1:0] HALF_U = WIDE_W'(1) <<< (UNIT_BITS - 1);
    localparam logic signed [OPND_W-1:0] RATE   = OPND_W'(RATE_STEP_LIMIT);

    state_t state_reg;
    op_t    op_reg;

    // configuration registers
    logic signed [DATA_W-1:0] kp_reg, ki_reg, kd_reg, floor_reg, ceil_reg;
    logic [UNIT_W-1:0]        dt_reg, weight_reg;
    logic [DATA_W-2:0]        ibound_reg;

    // loop state and working registers
    logic signed [DATA_W-1:0] meas_reg, target_reg;
    logic signed [DATA_W-1:0] filt_reg, e1_reg, e2_reg, drive_reg, integ_reg;
    logic signed [DATA_W-1:0] e_reg, de1_reg, de2_reg, p1_reg, p2_reg, p3_reg, du_reg;
    logic signed [DATA_W-1:0] u_reg;
    logic                     lim_flag_reg, skip_reg;
    logic signed [DATA_W-1:0] out_drive_reg;
    logic                     out_lim_reg, out_valid_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    ipid_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    logic signed [WIDE_W-1:0] prod_w;
    logic signed [DATA_W-1:0] rnd_f, rnd_u, filt_next, integ_next;
    logic signed [DATA_W-1:0] e_next, de1_next, de2_next;
    logic signed [DATA_W-1:0] ibound_pos, ibound_neg;
    logic signed [OPND_W-1:0] raw, lim, upper, lower;
    logic                     out_free;

    // rounding of the multiplier result
    always_comb begin
        prod_w     = WIDE_W'(mrsp.product);
        rnd_f      = sat32((prod_w + HALF_F) >>> FRACTION_BITS);
        rnd_u      = sat32((prod_w + HALF_U) >>> UNIT_BITS);
        filt_next  = sat32(((WIDE_W'(filt_reg) <<< UNIT_BITS) + prod_w + HALF_U) >>> UNIT_BITS);
        integ_next = sat32(WIDE_W'(integ_reg) + WIDE_W'(rnd_u));
    end

    // error and its differences
    always_comb begin
        e_next   = sat32(WIDE_W'(target_reg) - WIDE_W'(filt_reg));
        de1_next = sat32(WIDE_W'(e_next) - WIDE_W'(e1_reg));
        de2_next = sat32(WIDE_W'(e_next) - (WIDE_W'(e1_reg) <<< 1) + WIDE_W'(e2_reg));
        ibound_pos = {1'b0, ibound_reg};
        ibound_neg = -ibound_pos;
    end

    // rate limit then output clamp
    always_comb begin
        raw   = OPND_W'(drive_reg) + OPND_W'(du_reg);
        upper = OPND_W'(drive_reg) + RATE;
        lower = OPND_W'(drive_reg) - RATE;
        lim   = raw;
        if (lim > upper) begin
            lim = upper;
        end
        if (lim < lower) begin
            lim = lower;
        end
        if (lim > OPND_W'(ceil_reg)) begin
            lim = OPND_W'(ceil_reg);
        end
        if (lim < OPND_W'(floor_reg)) begin
            lim = OPND_W'(floor_reg);
        end
    end

    // multiplier operand selection
    always_comb begin
        mreq.start = (state_reg == ST_ISSUE);
        mreq.a     = '0;
        mreq.b     = '0;
        case (op_reg)
            OP_FILT: begin
                mreq.a = OPND_W'(meas_reg) - OPND_W'(filt_reg);
                mreq.b = OPND_W'(weight_reg);
            end
            OP_INT: begin
                mreq.a = OPND_W'(e_reg);
                mreq.b = OPND_W'(dt_reg);
            end
            OP_P: begin
                mreq.a = OPND_W'(kp_reg);
                mreq.b = OPND_W'(de1_reg);
            end
            OP_I: begin
                mreq.a = OPND_W'(ki_reg);
                mreq.b = OPND_W'(integ_reg);
            end
            OP_D: begin
                mreq.a = OPND_W'(kd_reg);
                mreq.b = OPND_W'(de2_reg);
            end
            default: begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            dt_reg     <= UNIT_ONE;
            floor_reg  <= 32'sh8000_0000;
            ceil_reg   <= 32'sh7FFF_FFFF;
            weight_reg <= UNIT_ONE;
            ibound_reg <= '1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KP:     kp_reg     <= cfg_data;
                REG_KI:     ki_reg     <= cfg_data;
                REG_KD:     kd_reg     <= cfg_data;
                REG_DT:     dt_reg     <= unit_clip(cfg_data);
                REG_FLOOR:  floor_reg  <= cfg_data;
                REG_CEIL:   ceil_reg   <= cfg_data;
                REG_WEIGHT: weight_reg <= unit_clip(cfg_data);
                REG_IBOUND: ibound_reg <= cfg_data[DATA_W-2:0];
                default: ;
            endcase
        end
    end

    // sequencer and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_FILT;
            filt_reg  <= '0;
            e1_reg    <= '0;
            e2_reg    <= '0;
            drive_reg <= '0;
            integ_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        meas_reg   <= s_measured_value;
                        target_reg <= s_setpoint;
                        if (s_restart) begin
                            filt_reg  <= '0;
                            e1_reg    <= '0;
                            e2_reg    <= '0;
                            drive_reg <= '0;
                            integ_reg <= '0;
                        end
                        op_reg    <= OP_FILT;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (mrsp.done) begin
                        case (op_reg)
                            OP_FILT: begin
                                filt_reg  <= filt_next;
                                state_reg <= ST_ERR;
                            end
                            OP_INT: begin
                                if (!skip_reg) begin
                                    integ_reg <= integ_next;
                                end
                                state_reg <= ST_CLAMP;
                            end
                            OP_P: begin
                                p1_reg    <= rnd_f;
                                op_reg    <= OP_I;
                                state_reg <= ST_ISSUE;
                            end
                            OP_I: begin
                                p2_reg    <= rnd_f;
                                op_reg    <= OP_D;
                                state_reg <= ST_ISSUE;
                            end
                            default: begin
                                p3_reg    <= rnd_f;
                                state_reg <= ST_SUM;
                            end
                        endcase
                    end
                end
                ST_ERR: begin
                    e_reg     <= e_next;
                    de1_reg   <= de1_next;
                    de2_reg   <= de2_next;
                    // anti-windup: hold the integral while pushing into a bound
                    skip_reg  <= (drive_reg >= ceil_reg && e_next > 0) ||
                                 (drive_reg <= floor_reg && e_next < 0);
                    op_reg    <= OP_INT;
                    state_reg <= ST_ISSUE;
                end
                ST_CLAMP: begin
                    if (integ_reg > ibound_pos) begin
                        integ_reg <= ibound_pos;
                    end else if (integ_reg < ibound_neg) begin
                        integ_reg <= ibound_neg;
                    end
                    op_reg    <= OP_P;
                    state_reg <= ST_ISSUE;
                end
                ST_SUM: begin
                    du_reg    <= sat32(WIDE_W'(p1_reg) + WIDE_W'(p2_reg) + WIDE_W'(p3_reg));
                    state_reg <= ST_LIM;
                end
                ST_LIM: begin
                    u_reg        <= lim[DATA_W-1:0];
                    lim_flag_reg <= (lim != raw);
                    drive_reg    <= lim[DATA_W-1:0];
                    e2_reg       <= e1_reg;
                    e1_reg       <= e_reg;
                    state_reg    <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            out_drive_reg <= u_reg;
            out_lim_reg   <= lim_flag_reg;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_drive   = out_drive_reg;
    assign m_limited = out_lim_reg;

    // multiplier answers only while the sequencer waits for it
    a_mul_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mrsp.done |-> (state_reg == ST_WAIT))
        else $error("multiplier result outside wait state");

    // a new result only comes out of the output state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> $past(state_reg == ST_OUT))
        else $error("result raised without output state");

    // integral stays inside its bound after clamping
    a_int_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLAMP && !cfg_wr_en) |=>
            (integ_reg <= ibound_pos && integ_reg >= ibound_neg))
        else $error("integral outside bound");

endmodule
